// ----- hdl/rcpc_pkg.sv -----
package rcpc_pkg;

    localparam int T_W         = 32;
    localparam int FACE_W      = 3;
    localparam int EPS_W       = 17;
    localparam int LIMIT_W     = 31;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int TABLE_FACES = 6;

    localparam logic [ADDR_W-1:0]  REG_EPSILON_ADDR = 3'd0;
    localparam logic [EPS_W-1:0]   EPSILON_RESET    = 17'd66;
    localparam logic [LIMIT_W-1:0] LIMIT_ALL_ONES   = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef struct packed {
        logic signed [T_W-1:0] origin_x;
        logic signed [T_W-1:0] origin_y;
        logic signed [T_W-1:0] origin_z;
        logic signed [T_W-1:0] dir_x;
        logic signed [T_W-1:0] dir_y;
        logic signed [T_W-1:0] dir_z;
        logic [LIMIT_W-1:0]    ray_limit;
    } rcpc_in_t;

    typedef struct packed {
        logic                  hit;
        logic                  near_valid;
        logic signed [T_W-1:0] near_t;
        logic [FACE_W-1:0]     near_face;
        logic                  far_valid;
        logic signed [T_W-1:0] far_t;
        logic [FACE_W-1:0]     far_face;
    } rcpc_out_t;

    // Face table: +y, -y, -x, +x, +z, -z; every plane offset is -1.
    function automatic axis_t face_axis(input logic [FACE_W-1:0] f);
        axis_t a;
        unique case (f)
            3'd0, 3'd1: a = AXIS_Y;
            3'd2, 3'd3: a = AXIS_X;
            default:    a = AXIS_Z;
        endcase
        return a;
    endfunction

    function automatic logic face_neg(input logic [FACE_W-1:0] f);
        logic n;
        unique case (f)
            3'd1, 3'd2, 3'd5: n = 1'b1;
            default:          n = 1'b0;
        endcase
        return n;
    endfunction

endpackage

// ----- hdl/ray_convex_polyhedron_clip.sv -----
// Ray against unit cube clipper (Cyrus-Beck), Q16.16 fixed point.
//
// Input channel s_valid/s_ready/s_data carries one ray per transfer:
// origin, direction and a length limit (all ones = unlimited). Result
// channel m_valid/m_ready/m_data returns one result per ray in order:
// near/far parameters, faces and their validity, all zero on a miss.
// Register epsilon (APB, address 0) sets the parallel threshold and
// the minimum hit distance; write it only while no ray is in flight.
//
// From input transfer to m_valid the path runs through registered stages:
// face setup, magnitude and overflow check, 32 restoring divider stages,
// one quotient bit each, saturation, face reduction and the output
// register. One ray is accepted every cycle while the skid register
// is empty; the per-face dividers are fully pipelined, all in parallel.
//
// Reset clears all valid bits and loads epsilon with 66. When the
// receiver stalls, the output register holds and one more result lands
// in a skid register; only then does the pipeline and s_ready stop.
module ray_convex_polyhedron_clip
    import rcpc_pkg::*;
#(
    parameter int NUM_FACES = 6,
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rcpc_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rcpc_out_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Repeated table entries never move a bound, so only distinct faces matter.
    localparam int NF = (NUM_FACES < TABLE_FACES) ? NUM_FACES : TABLE_FACES;
    localparam int VW = T_W + 1;           // dist / den width
    localparam int NW = T_W + FRAC_BITS;   // numerator magnitude width
    localparam int DW = T_W;               // denominator magnitude width
    localparam int QW = T_W;               // quotient bits
    localparam int CW = DW + QW;           // remainder compare width
    localparam logic signed [VW-1:0] ONE_FX = VW'(1) << FRAC_BITS;

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] quo;
        logic          neg;
        logic          ovf;
        logic          par_skip;
        logic          par_miss;
        logic          is_far;
    } face_div_t;

    typedef struct packed {
        logic signed [T_W-1:0] t;
        logic                  par_skip;
        logic                  par_miss;
        logic                  is_far;
    } face_t_t;

    // ---------------- configuration ----------------
    logic [EPS_W-1:0] eps_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_EPSILON_ADDR);
    assign prdata = (paddr == REG_EPSILON_ADDR) ? DATA_W'(eps_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPSILON_RESET;
        end else if (cfg_wr) begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    // ---------------- flow control ----------------
    // The pipeline advances as a whole while the skid register is empty.
    logic en;
    logic skid_v_reg;

    assign en      = !skid_v_reg;
    assign s_ready = en;

    // ---------------- stage A: dist and den per face ----------------
    logic                  a_v_reg;
    logic signed [VW-1:0]  a_dist_reg [NF];
    logic signed [VW-1:0]  a_den_reg  [NF];
    logic [LIMIT_W-1:0]    a_lim_reg;
    logic signed [VW-1:0]  a_dist_next [NF];
    logic signed [VW-1:0]  a_den_next  [NF];

    always_comb begin
        logic signed [VW-1:0] o;
        logic signed [VW-1:0] d;
        for (int i = 0; i < NF; i++) begin
            unique case (face_axis(FACE_W'(i)))
                AXIS_X: begin
                    o = VW'(s_data.origin_x);
                    d = VW'(s_data.dir_x);
                end
                AXIS_Y: begin
                    o = VW'(s_data.origin_y);
                    d = VW'(s_data.dir_y);
                end
                default: begin
                    o = VW'(s_data.origin_z);
                    d = VW'(s_data.dir_z);
                end
            endcase
            if (face_neg(FACE_W'(i))) begin
                a_dist_next[i] = -o - ONE_FX;
                a_den_next[i]  = -d;
            end else begin
                a_dist_next[i] = o - ONE_FX;
                a_den_next[i]  = d;
            end
        end
    end

    // ---------------- stage B: magnitudes, parallel test, overflow ----------------
    logic      div_v_reg   [QW+1];
    face_div_t div_reg     [QW+1][NF];
    logic [LIMIT_W-1:0] div_lim_reg [QW+1];
    face_div_t b_next [NF];

    always_comb begin
        logic [VW-1:0] adist;
        logic [VW-1:0] aden;
        logic [NW-1:0] num;
        logic          par;
        for (int i = 0; i < NF; i++) begin
            adist = a_dist_reg[i][VW-1] ? VW'(-a_dist_reg[i]) : VW'(a_dist_reg[i]);
            aden  = a_den_reg[i][VW-1]  ? VW'(-a_den_reg[i])  : VW'(a_den_reg[i]);
            num   = {adist[DW-1:0], {FRAC_BITS{1'b0}}};
            par   = (a_den_reg[i] == '0) || (aden < VW'(eps_reg));
            b_next[i].rem      = CW'(num);
            b_next[i].den      = aden[DW-1:0];
            b_next[i].quo      = '0;
            // num = -dist, so its sign is the opposite of dist's.
            b_next[i].neg      = (a_dist_reg[i] > 0) ^ a_den_reg[i][VW-1];
            b_next[i].ovf      = CW'(num) >= {aden[DW-1:0], {QW{1'b0}}};
            b_next[i].par_skip = par && a_dist_reg[i][VW-1];
            b_next[i].par_miss = par && !a_dist_reg[i][VW-1];
            b_next[i].is_far   = !a_den_reg[i][VW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_dist_reg     <= a_dist_next;
            a_den_reg      <= a_den_next;
            a_lim_reg      <= s_data.ray_limit;
            div_reg[0]     <= b_next;
            div_lim_reg[0] <= a_lim_reg;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar k = 0; k < QW; k++) begin : g_div
        face_div_t step_next [NF];

        always_comb begin
            logic [CW-1:0] sub;
            for (int i = 0; i < NF; i++) begin
                step_next[i] = div_reg[k][i];
                sub = CW'(div_reg[k][i].den) << (QW - 1 - k);
                if (div_reg[k][i].rem >= sub) begin
                    step_next[i].rem            = div_reg[k][i].rem - sub;
                    step_next[i].quo[QW - 1 - k] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[k+1]     <= step_next;
                div_lim_reg[k+1] <= div_lim_reg[k];
            end
        end
    end

    // ---------------- stage C: sign and saturation ----------------
    logic               c_v_reg;
    face_t_t            c_reg [NF];
    logic [LIMIT_W-1:0] c_lim_reg;
    face_t_t            c_next [NF];

    always_comb begin
        logic [QW-1:0] q;
        for (int i = 0; i < NF; i++) begin
            q = div_reg[QW][i].quo;
            if (div_reg[QW][i].neg) begin
                if (div_reg[QW][i].ovf || (q > {1'b1, {(QW-1){1'b0}}})) begin
                    c_next[i].t = {1'b1, {(T_W-1){1'b0}}};
                end else begin
                    c_next[i].t = -$signed(q);
                end
            end else begin
                if (div_reg[QW][i].ovf || q[QW-1]) begin
                    c_next[i].t = {1'b0, {(T_W-1){1'b1}}};
                end else begin
                    c_next[i].t = $signed(q);
                end
            end
            c_next[i].par_skip = div_reg[QW][i].par_skip;
            c_next[i].par_miss = div_reg[QW][i].par_miss;
            c_next[i].is_far   = div_reg[QW][i].is_far;
        end
    end

    // ---------------- stage D: narrow the bounds over all faces ----------------
    logic                  d_v_reg;
    logic                  d_miss_reg;
    logic                  d_near_set_reg;
    logic                  d_far_set_reg;
    logic signed [T_W-1:0] d_near_t_reg;
    logic signed [T_W-1:0] d_far_t_reg;
    logic [FACE_W-1:0]     d_near_face_reg;
    logic [FACE_W-1:0]     d_far_face_reg;
    logic [LIMIT_W-1:0]    d_lim_reg;

    logic                  d_miss_next;
    logic                  d_near_set_next;
    logic                  d_far_set_next;
    logic signed [T_W-1:0] d_near_t_next;
    logic signed [T_W-1:0] d_far_t_next;
    logic [FACE_W-1:0]     d_near_face_next;
    logic [FACE_W-1:0]     d_far_face_next;

    // Lower faces win ties: a bound moves only on a strictly better t.
    always_comb begin
        d_miss_next      = 1'b0;
        d_near_set_next  = 1'b0;
        d_far_set_next   = 1'b0;
        d_near_t_next    = {1'b1, {(T_W-1){1'b0}}};
        d_far_t_next     = {1'b0, {(T_W-1){1'b1}}};
        d_near_face_next = '0;
        d_far_face_next  = '0;
        for (int i = 0; i < NF; i++) begin
            if (c_reg[i].par_miss) begin
                d_miss_next = 1'b1;
            end else if (!c_reg[i].par_skip) begin
                if (c_reg[i].is_far) begin
                    if (!d_far_set_next || (c_reg[i].t < d_far_t_next)) begin
                        d_far_t_next    = c_reg[i].t;
                        d_far_face_next = FACE_W'(i);
                        d_far_set_next  = 1'b1;
                    end
                end else begin
                    if (!d_near_set_next || (c_reg[i].t > d_near_t_next)) begin
                        d_near_t_next    = c_reg[i].t;
                        d_near_face_next = FACE_W'(i);
                        d_near_set_next  = 1'b1;
                    end
                end
            end
        end
    end

    // ---------------- result assembly ----------------
    rcpc_out_t p_data;

    always_comb begin
        logic                  miss;
        logic                  unlim;
        logic signed [T_W-1:0] eps_s;
        logic signed [T_W-1:0] lim_s;
        logic                  nv;
        logic                  fv;
        miss  = d_miss_reg ||
                (d_near_set_reg && d_far_set_reg && (d_near_t_reg >= d_far_t_reg));
        unlim = (d_lim_reg == LIMIT_ALL_ONES);
        eps_s = $signed(T_W'(eps_reg));
        lim_s = $signed({1'b0, d_lim_reg});
        nv = d_near_set_reg && (d_near_t_reg > eps_s) && (unlim || (d_near_t_reg < lim_s));
        fv = d_far_set_reg && (d_far_t_reg > eps_s) && (unlim || (d_far_t_reg < lim_s));
        if (miss) begin
            p_data = '0;
        end else begin
            p_data.hit        = nv || fv;
            p_data.near_valid = nv;
            p_data.near_t     = d_near_t_reg;
            p_data.near_face  = d_near_face_reg;
            p_data.far_valid  = fv;
            p_data.far_t      = d_far_t_reg;
            p_data.far_face   = d_far_face_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg            <= c_next;
            c_lim_reg        <= div_lim_reg[QW];
            d_miss_reg       <= d_miss_next;
            d_near_set_reg   <= d_near_set_next;
            d_far_set_reg    <= d_far_set_next;
            d_near_t_reg     <= d_near_t_next;
            d_far_t_reg      <= d_far_t_next;
            d_near_face_reg  <= d_near_face_next;
            d_far_face_reg   <= d_far_face_next;
            d_lim_reg        <= c_lim_reg;
        end
    end

    // Valid bits travel alongside the payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            for (int k = 0; k <= QW; k++) begin
                div_v_reg[k] <= 1'b0;
            end
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg      <= s_valid;
            div_v_reg[0] <= a_v_reg;
            for (int k = 0; k < QW; k++) begin
                div_v_reg[k+1] <= div_v_reg[k];
            end
            c_v_reg <= div_v_reg[QW];
            d_v_reg <= c_v_reg;
        end
    end

    // ---------------- output register and skid ----------------
    logic      m_v_reg;
    rcpc_out_t m_data_reg;
    rcpc_out_t skid_reg;
    logic      deliver;
    logic      take;

    assign deliver = en && d_v_reg;
    assign take    = m_v_reg && m_ready;
    assign m_valid = m_v_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg    <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (deliver) begin
                if (!m_v_reg || take) begin
                    m_v_reg <= 1'b1;
                end else begin
                    skid_v_reg <= 1'b1;
                end
            end else if (take) begin
                if (skid_v_reg) begin
                    skid_v_reg <= 1'b0;
                end else begin
                    m_v_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (deliver) begin
            if (!m_v_reg || take) begin
                m_data_reg <= p_data;
            end else begin
                skid_reg <= p_data;
            end
        end else if (take && skid_v_reg) begin
            m_data_reg <= skid_reg;
        end
    end

endmodule
